FILE: hdl/sbdft_pkg.sv
// Shared types, constants and arithmetic helpers for the single-bin 2D DFT accumulator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sbdft_pkg;

  localparam int MAX_ROW_DEF     = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int PH_W       = 16;  // Q1.15 phase and step words
  localparam int ROWLEN_W   = 9;
  localparam int SCALE_W    = 32;  // Q16.16 area factor
  localparam int OUT_W      = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DEPTH  = 8;   // result queue entries, power of two

  localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RST  = 9'd64;
  localparam logic signed [PH_W-1:0] START_RE_RST = 16'sh7FFF;
  localparam logic signed [PH_W-1:0] START_IM_RST = 16'sh0000;
  localparam logic signed [PH_W-1:0] STEP_RE_RST  = 16'sh7FFF;
  localparam logic signed [PH_W-1:0] STEP_IM_RST  = 16'sh0000;
  localparam logic [SCALE_W-1:0] AREA_SCALE_RST   = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_LENGTH  = 3'd0,
    CFG_START_RE    = 3'd1,
    CFG_START_IM    = 3'd2,
    CFG_COL_STEP_RE = 3'd3,
    CFG_COL_STEP_IM = 3'd4,
    CFG_ROW_STEP_RE = 3'd5,
    CFG_ROW_STEP_IM = 3'd6,
    CFG_AREA_SCALE  = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [ROWLEN_W-1:0]    row_length;
    logic signed [PH_W-1:0] start_re;
    logic signed [PH_W-1:0] start_im;
    logic signed [PH_W-1:0] col_step_re;
    logic signed [PH_W-1:0] col_step_im;
    logic signed [PH_W-1:0] row_step_re;
    logic signed [PH_W-1:0] row_step_im;
  } phase_cfg_t;

  // per-stage transaction marks
  typedef struct packed {
    logic valid;
    logic last;
  } item_ctl_t;

  // Q3.30 sum back to Q1.15: round half up, then saturate
  function automatic logic signed [PH_W-1:0] rot_round(input logic signed [2*PH_W:0] x);
    logic signed [2*PH_W+1:0] t;
    logic signed [PH_W+2:0]   sh;
    t  = (2*PH_W+2)'(x) + (2*PH_W+2)'(16384);
    sh = (PH_W+3)'(t >>> 15);
    if (sh > (PH_W+3)'(32767)) begin
      return 16'sh7FFF;
    end else if (sh < -(PH_W+3)'(32768)) begin
      return 16'sh8000;
    end
    return sh[PH_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/single_bin_2d_dft_accumulator.sv
// Single-bin 2D DFT accumulator: top level with configuration registers and flow control.
// Depends on sbdft_pkg, sbdft_phase, sbdft_accum, sbdft_scale and sbdft_outq.
//
// Usage:
//   Samples enter on the s_axis channel in raster order, one per transaction;
//   s_axis_tlast marks the last sample of a frame. Each frame yields one
//   result on m_axis: the complex sum scaled by area_scale and saturated to
//   48 bits per part. Frames of any length are summed; only tlast ends one.
//   Configuration registers are to be written through cfg_we_i/cfg_idx_i/cfg_data_i
//   only while no frame is in progress; the user must keep to this, the block does not
//   enforce it. The phase registers take effect at the next frame start.
//   Throughput: one sample per cycle while s_axis_tready is high, set by the combinational phase rotator.
//   Result path: input register, accumulator product and sum registers, scaler
//   magnitude, product and rounding registers, queue memory, then output register.
//   Up to 8 results may be outstanding; s_axis_tready drops only when 8
//   results are queued or in flight, so a stalled receiver holds off the
//   input after that many frames. Results leave in frame order.
//   Reset clears the accumulators, queue and flow control and restores the
//   register defaults (row length 64, unit phase and steps, area factor 1.0).
`default_nettype none

module single_bin_2d_dft_accumulator
  import sbdft_pkg::*;
#(
  parameter int MAX_ROW     = MAX_ROW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // tdata: sample [SAMPLE_BITS-1:0], zero padded to whole bytes
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  input  wire logic                                s_axis_tlast,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: bin_re [47:0], bin_im [95:48]
  output logic [2*OUT_W-1:0]                       m_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  input  wire logic                                cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]                cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]               cfg_data_i
);

  localparam int PEND_W = $clog2(OUT_DEPTH + 1);

  phase_cfg_t          pcfg_q;
  logic [SCALE_W-1:0]  area_scale_q;
  logic [PEND_W-1:0]   pending_q;
  logic                in_acc, out_acc;

  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [PH_W-1:0]        ph_re, ph_im;
  item_ctl_t                     ctl;
  logic [OUT_W-1:0]              sum_re, sum_im, res_re, res_im;
  logic                          sum_valid, res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcfg_q.row_length  <= ROW_LENGTH_RST;
      pcfg_q.start_re    <= START_RE_RST;
      pcfg_q.start_im    <= START_IM_RST;
      pcfg_q.col_step_re <= STEP_RE_RST;
      pcfg_q.col_step_im <= STEP_IM_RST;
      pcfg_q.row_step_re <= STEP_RE_RST;
      pcfg_q.row_step_im <= STEP_IM_RST;
      area_scale_q       <= AREA_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_LENGTH:  pcfg_q.row_length  <= cfg_data_i[ROWLEN_W-1:0];
        CFG_START_RE:    pcfg_q.start_re    <= cfg_data_i[PH_W-1:0];
        CFG_START_IM:    pcfg_q.start_im    <= cfg_data_i[PH_W-1:0];
        CFG_COL_STEP_RE: pcfg_q.col_step_re <= cfg_data_i[PH_W-1:0];
        CFG_COL_STEP_IM: pcfg_q.col_step_im <= cfg_data_i[PH_W-1:0];
        CFG_ROW_STEP_RE: pcfg_q.row_step_re <= cfg_data_i[PH_W-1:0];
        CFG_ROW_STEP_IM: pcfg_q.row_step_im <= cfg_data_i[PH_W-1:0];
        CFG_AREA_SCALE:  area_scale_q       <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // credit for results in the pipeline or the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + PEND_W'(in_acc && s_axis_tlast) - PEND_W'(out_acc);
    end
  end

  assign s_axis_tready = (pending_q < PEND_W'(OUT_DEPTH));

  sbdft_phase #(
    .MAX_ROW    (MAX_ROW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (pcfg_q),
    .accept_i(in_acc),
    .sample_i(s_axis_tdata[SAMPLE_BITS-1:0]),
    .last_i  (s_axis_tlast),
    .x_o     (x),
    .ph_re_o (ph_re),
    .ph_im_o (ph_im),
    .ctl_o   (ctl)
  );

  sbdft_accum #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .x_i        (x),
    .ph_re_i    (ph_re),
    .ph_im_i    (ph_im),
    .ctl_i      (ctl),
    .sum_re_o   (sum_re),
    .sum_im_o   (sum_im),
    .sum_valid_o(sum_valid)
  );

  sbdft_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scale_i    (area_scale_q),
    .sum_re_i   (sum_re),
    .sum_im_i   (sum_im),
    .valid_i    (sum_valid),
    .res_re_o   (res_re),
    .res_im_o   (res_im),
    .res_valid_o(res_valid)
  );

  sbdft_outq #(
    .DEPTH(OUT_DEPTH),
    .W    (2 * OUT_W)
  ) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_valid),
    .wdata_i ({res_im, res_re}),
    .tvalid_o(m_axis_tvalid),
    .tready_i(m_axis_tready),
    .tdata_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

FILE: hdl/sbdft_phase.sv
// Input register and phase recurrence: tracks column/row phasors and the column count.
// Depends on sbdft_pkg.
`default_nettype none

module sbdft_phase
  import sbdft_pkg::*;
#(
  parameter int MAX_ROW     = MAX_ROW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire phase_cfg_t                    cfg_i,
  input  wire logic                          accept_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          last_i,
  output logic signed [SAMPLE_BITS-1:0]      x_o,
  output logic signed [PH_W-1:0]             ph_re_o,
  output logic signed [PH_W-1:0]             ph_im_o,
  output item_ctl_t                          ctl_o
);

  localparam int CW = $clog2(MAX_ROW);
  localparam int LW = (CW + 1 > ROWLEN_W) ? CW + 1 : ROWLEN_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_ROW);

  logic                   open_q, open_d;
  logic [CW-1:0]          cc_q, cc_d, cc_used;
  logic signed [PH_W-1:0] col_re_q, col_im_q, row_re_q, row_im_q;
  logic signed [PH_W-1:0] col_re_d, col_im_d, row_re_d, row_im_d;
  logic signed [PH_W-1:0] col_re_u, col_im_u, row_re_u, row_im_u;
  logic signed [PH_W-1:0] a_re, a_im, s_re, s_im, rot_re, rot_im;
  logic signed [2*PH_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic [LW-1:0]          len_ext, len_m1;
  logic                   row_end;

  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [PH_W-1:0]        ph_re_q, ph_im_q;
  item_ctl_t                     ctl_q;

  always_comb begin
    len_ext = LW'(cfg_i.row_length);
    if (len_ext < LW'(2)) begin
      len_m1 = LW'(1);
    end else if (len_ext > MAX_L) begin
      len_m1 = MAX_L - LW'(1);
    end else begin
      len_m1 = len_ext - LW'(1);
    end

    // first sample of a frame starts from the start phase
    cc_used  = open_q ? cc_q : '0;
    col_re_u = open_q ? col_re_q : cfg_i.start_re;
    col_im_u = open_q ? col_im_q : cfg_i.start_im;
    row_re_u = open_q ? row_re_q : cfg_i.start_re;
    row_im_u = open_q ? row_im_q : cfg_i.start_im;
    row_end  = (LW'(cc_used) >= len_m1);

    // one shared complex rotator: row step at row end, column step otherwise
    a_re = row_end ? row_re_u : col_re_u;
    a_im = row_end ? row_im_u : col_im_u;
    s_re = row_end ? cfg_i.row_step_re : cfg_i.col_step_re;
    s_im = row_end ? cfg_i.row_step_im : cfg_i.col_step_im;
    p_rr = a_re * s_re;
    p_ii = a_im * s_im;
    p_ri = a_re * s_im;
    p_ir = a_im * s_re;
    rot_re = rot_round((2*PH_W+1)'(p_rr) - (2*PH_W+1)'(p_ii));
    rot_im = rot_round((2*PH_W+1)'(p_ri) + (2*PH_W+1)'(p_ir));

    open_d   = open_q;
    cc_d     = cc_q;
    col_re_d = col_re_q;
    col_im_d = col_im_q;
    row_re_d = row_re_q;
    row_im_d = row_im_q;
    if (accept_i) begin
      col_re_d = rot_re;
      col_im_d = rot_im;
      row_re_d = row_end ? rot_re : row_re_u;
      row_im_d = row_end ? rot_im : row_im_u;
      if (last_i) begin
        open_d = 1'b0;
        cc_d   = '0;
      end else begin
        open_d = 1'b1;
        cc_d   = row_end ? '0 : cc_used + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      cc_q     <= '0;
      col_re_q <= START_RE_RST;
      col_im_q <= START_IM_RST;
      row_re_q <= START_RE_RST;
      row_im_q <= START_IM_RST;
      ctl_q    <= '0;
    end else begin
      open_q   <= open_d;
      cc_q     <= cc_d;
      col_re_q <= col_re_d;
      col_im_q <= col_im_d;
      row_re_q <= row_re_d;
      row_im_q <= row_im_d;
      ctl_q    <= '{valid: accept_i, last: last_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      x_q     <= sample_i;
      ph_re_q <= col_re_u;
      ph_im_q <= col_im_u;
    end
  end

  assign x_o     = x_q;
  assign ph_re_o = ph_re_q;
  assign ph_im_o = ph_im_q;
  assign ctl_o   = ctl_q;

endmodule

`default_nettype wire

FILE: hdl/sbdft_accum.sv
// Sample-times-phase product stage and 48-bit complex accumulators; emits the frame sum.
// Depends on sbdft_pkg.
`default_nettype none

module sbdft_accum
  import sbdft_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic signed [SAMPLE_BITS-1:0] x_i,
  input  wire logic signed [PH_W-1:0]        ph_re_i,
  input  wire logic signed [PH_W-1:0]        ph_im_i,
  input  wire item_ctl_t                     ctl_i,
  output logic [OUT_W-1:0]                   sum_re_o,
  output logic [OUT_W-1:0]                   sum_im_o,
  output logic                               sum_valid_o
);

  localparam int PW = SAMPLE_BITS + PH_W;

  logic signed [PW-1:0] prod_re_q, prod_im_q;
  item_ctl_t            ctl_m_q;
  logic [OUT_W-1:0]     acc_re_q, acc_im_q, sum_re_q, sum_im_q;
  logic [OUT_W-1:0]     sum_re_d, sum_im_d;
  logic                 sv_q;

  always_ff @(posedge clk_i) begin
    prod_re_q <= x_i * ph_re_i;
    prod_im_q <= x_i * ph_im_i;
  end

  // sums wrap modulo 2^48
  assign sum_re_d = acc_re_q + OUT_W'(prod_re_q);
  assign sum_im_d = acc_im_q + OUT_W'(prod_im_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_m_q  <= '0;
      acc_re_q <= '0;
      acc_im_q <= '0;
      sv_q     <= 1'b0;
    end else begin
      ctl_m_q <= ctl_i;
      sv_q    <= ctl_m_q.valid && ctl_m_q.last;
      if (ctl_m_q.valid) begin
        if (ctl_m_q.last) begin
          acc_re_q <= '0;
          acc_im_q <= '0;
        end else begin
          acc_re_q <= sum_re_d;
          acc_im_q <= sum_im_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_m_q.valid && ctl_m_q.last) begin
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
    end
  end

  assign sum_re_o    = sum_re_q;
  assign sum_im_o    = sum_im_q;
  assign sum_valid_o = sv_q;

endmodule

`default_nettype wire

FILE: hdl/sbdft_scale.sv
// Area scaling of the frame sum: magnitude, split 32x32 and 16x32 products, rounding, saturation.
// Depends on sbdft_pkg.
`default_nettype none

module sbdft_scale
  import sbdft_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [SCALE_W-1:0]  scale_i,
  input  wire logic [OUT_W-1:0]    sum_re_i,
  input  wire logic [OUT_W-1:0]    sum_im_i,
  input  wire logic                valid_i,
  output logic [OUT_W-1:0]         res_re_o,
  output logic [OUT_W-1:0]         res_im_o,
  output logic                     res_valid_o
);

  localparam int LANES = 2;
  localparam int HI_W  = OUT_W - 16;
  localparam int LO_W  = 16 + SCALE_W;
  localparam int R_W   = HI_W + SCALE_W;
  localparam logic [R_W-1:0] LIM = R_W'(1) << (OUT_W - 1);

  logic [LANES-1:0][OUT_W-1:0] sum_in, mag_q, res;
  logic [LANES-1:0]            neg1_q, neg2_q, neg3_q;
  logic [LANES-1:0][R_W-1:0]   hi_q, r_q;
  logic [LANES-1:0][LO_W-1:0]  lo_q;
  logic [2:0]                  v_q;
  logic [R_W-1:0]              rr;

  assign sum_in[0] = sum_re_i;
  assign sum_in[1] = sum_im_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      neg1_q[l] <= sum_in[l][OUT_W-1];
      mag_q[l]  <= sum_in[l][OUT_W-1] ? (OUT_W'(0) - sum_in[l]) : sum_in[l];
      neg2_q[l] <= neg1_q[l];
      hi_q[l]   <= R_W'(mag_q[l][OUT_W-1:16]) * R_W'(scale_i);
      lo_q[l]   <= LO_W'(mag_q[l][15:0]) * LO_W'(scale_i);
      neg3_q[l] <= neg2_q[l];
      r_q[l]    <= hi_q[l] + R_W'((lo_q[l] + LO_W'(32768)) >> 16);
    end
  end

  // saturate the magnitude, then restore the sign
  always_comb begin
    rr = '0;
    for (int l = 0; l < LANES; l++) begin
      if (!neg3_q[l]) begin
        rr     = (r_q[l] > LIM - R_W'(1)) ? LIM - R_W'(1) : r_q[l];
        res[l] = rr[OUT_W-1:0];
      end else begin
        rr     = (r_q[l] > LIM) ? LIM : r_q[l];
        res[l] = OUT_W'(0) - rr[OUT_W-1:0];
      end
    end
  end

  assign res_re_o    = res[0];
  assign res_im_o    = res[1];
  assign res_valid_o = v_q[2];

endmodule

`default_nettype wire

FILE: hdl/sbdft_outq.sv
// Result queue: small memory plus a registered output stage feeding the master channel.
// Depends on sbdft_pkg for the default depth and width.
`default_nettype none

module sbdft_outq
  import sbdft_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH,
  parameter int W     = 2 * OUT_W
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         wr_i,
  input  wire logic [W-1:0] wdata_i,
  output logic              tvalid_o,
  input  wire logic         tready_i,
  output logic [W-1:0]      tdata_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;
  logic            ov_q, load;
  logic [W-1:0]    out_q;

  // refill the output register when it is empty or being taken
  assign load = (cnt_q != '0) && (!ov_q || tready_i);

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
    if (load) begin
      out_q <= mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (load) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
        ov_q     <= 1'b1;
      end else if (tready_i) begin
        ov_q <= 1'b0;
      end
      cnt_q <= cnt_q + CNTW'(wr_i) - CNTW'(load);
    end
  end

  assign tvalid_o = ov_q;
  assign tdata_o  = out_q;

endmodule

`default_nettype wire

FILE: hdl/sbdft_checker.sv
// Port-level checks for the single-bin 2D DFT accumulator, bound to the top level.
// Depends on sbdft_pkg and single_bin_2d_dft_accumulator.
`default_nettype none

module sbdft_checker
  import sbdft_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               s_axis_tvalid,
  input wire logic               s_axis_tready,
  input wire logic               s_axis_tlast,
  input wire logic               m_axis_tvalid,
  input wire logic               m_axis_tready,
  input wire logic [2*OUT_W-1:0] m_axis_tdata
);

  // last sample accepted to result on the output register
  localparam int RES_LAT = 8;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tlast))
    else $error("input stalled without a new frame result outstanding");

  a_res_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |-> ##RES_LAT m_axis_tvalid)
    else $error("no result offered after frame end");

endmodule

bind single_bin_2d_dft_accumulator sbdft_checker u_sbdft_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
